// ===== src/sha1_pkg.sv =====
// Shared constants, types and round functions of the SHA-1 hash engine.
`default_nettype none
package sha1_pkg;

  localparam int HASH_WORDS  = 5;
  localparam int HASH_AW     = 3;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 80;

  typedef logic [HASH_AW-1:0] hidx_t;
  typedef logic [31:0]        word_t;

  localparam word_t H0 = 32'h67452301;
  localparam word_t H1 = 32'hefcdab89;
  localparam word_t H2 = 32'h98badcfe;
  localparam word_t H3 = 32'h10325476;
  localparam word_t H4 = 32'hc3d2e1f0;

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t init_hash(input hidx_t idx);
    word_t r;
    case (idx)
      3'd0:    r = H0;
      3'd1:    r = H1;
      3'd2:    r = H2;
      3'd3:    r = H3;
      default: r = H4;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] round_stage(input logic [6:0] rnd);
    logic [1:0] s;
    if (rnd < 7'd20) begin
      s = 2'd0;
    end else if (rnd < 7'd40) begin
      s = 2'd1;
    end else if (rnd < 7'd60) begin
      s = 2'd2;
    end else begin
      s = 2'd3;
    end
    return s;
  endfunction

  function automatic word_t round_k(input logic [1:0] stage);
    word_t k;
    case (stage)
      2'd0:    k = K0;
      2'd1:    k = K1;
      2'd2:    k = K2;
      default: k = K3;
    endcase
    return k;
  endfunction

  function automatic word_t round_f(input logic [1:0] stage, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    case (stage)
      2'd0:    f = d ^ (b & (c ^ d));
      2'd2:    f = (b & c) | (d & (b | c));
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== src/sha1_hash_engine_unit.sv =====
// Top level of the SHA-1 hash engine: byte packing, padding, rounds and digest output.
//
// The engine hashes a byte stream into a 160-bit SHA-1 digest. Bytes are
// accepted one per cycle while a 64-byte block fills; each full block then
// holds off input while the chaining hash is loaded from its RAM, 80 rounds
// run at one per cycle and the result is added back into the RAM. A
// transaction with last set ends the message; padding then runs at one byte
// or one word per cycle, one or two more blocks are compressed, and the five
// digest words leave as five output transactions, word 0 first. The engine
// is ready for the next message right after word 4 is taken. No input is
// accepted while a block is compressed or a digest is out.
`default_nettype none
module sha1_hash_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_msg_byte,
  input  wire logic [3:0]  in_bit_count,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import sha1_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PAD      = 3'd1;
  localparam logic [2:0] ST_LOAD     = 3'd2;
  localparam logic [2:0] ST_ROUND    = 3'd3;
  localparam logic [2:0] ST_UPD      = 3'd4;
  localparam logic [2:0] ST_OUT_RD   = 3'd5;
  localparam logic [2:0] ST_OUT_LD   = 3'd6;
  localparam logic [2:0] ST_OUT_WAIT = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] msg_bits_r, msg_bits_nxt;
  logic        pad_r, pad_nxt;
  logic        need80_r, need80_nxt;
  logic        len_r, len_nxt;
  logic        final_r, final_nxt;
  logic        fresh_r, fresh_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [23:0] acc_r, acc_nxt;
  word_t       w_r [0:BLOCK_WORDS-1];
  word_t       v_r [0:HASH_WORDS-1];
  word_t       v_nxt [0:HASH_WORDS-1];
  word_t       out_word_r, out_word_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_lastw_r, out_lastw_nxt;

  logic        put_en;
  logic [7:0]  put_byte;
  logic        word_en;
  word_t       word_val;
  logic        w_shift;
  word_t       w_word;
  logic        blk_full;
  logic [3:0]  bits_add;
  logic [3:0]  bits_sat;
  logic [7:0]  part_byte;

  logic        ram_we;
  hidx_t       ram_waddr;
  word_t       ram_wdata;
  hidx_t       ram_raddr;
  word_t       ram_rdata;

  hidx_t       cnt_m1;
  word_t       hash_base;
  logic [1:0]  stage;
  word_t       t_sum;
  word_t       w_new;

  sha1_ram #(
    .WIDTH (32),
    .DEPTH (HASH_WORDS)
  ) u_chain_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_lastw_r;

  assign bits_sat  = (in_bit_count > 4'd8) ? 4'd8 : in_bit_count;
  assign part_byte = (in_msg_byte & ~(8'hFF >> bits_sat)) | (PAD_BYTE >> bits_sat);

  assign cnt_m1    = cnt_r - 3'd1;
  assign hash_base = fresh_r ? init_hash(cnt_m1) : ram_rdata;
  assign stage     = round_stage(round_r);
  assign t_sum     = {v_r[0][26:0], v_r[0][31:27]}
                   + round_f(stage, v_r[1], v_r[2], v_r[3])
                   + v_r[4] + round_k(stage) + w_r[0];
  assign w_new     = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign ram_raddr = (cnt_r == 3'(HASH_WORDS)) ? '0 : cnt_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    round_nxt     = round_r;
    msg_bits_nxt  = msg_bits_r;
    pad_nxt       = pad_r;
    need80_nxt    = need80_r;
    len_nxt       = len_r;
    final_nxt     = final_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_lastw_nxt = out_lastw_r;
    for (int i = 0; i < HASH_WORDS; i++) begin
      v_nxt[i] = v_r[i];
    end
    put_en    = 1'b0;
    put_byte  = '0;
    word_en   = 1'b0;
    word_val  = '0;
    bits_add  = '0;
    ram_we    = 1'b0;
    ram_waddr = cnt_m1;
    ram_wdata = hash_base + v_r[cnt_m1];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          put_en = 1'b1;
          if (!in_last) begin
            put_byte = in_msg_byte;
            bits_add = 4'd8;
          end else begin
            pad_nxt  = 1'b1;
            bits_add = bits_sat;
            if (bits_sat == 4'd0) begin
              put_byte = PAD_BYTE;
            end else if (bits_sat == 4'd8) begin
              put_byte   = in_msg_byte;
              need80_nxt = 1'b1;
            end else begin
              put_byte = part_byte;
            end
          end
          msg_bits_nxt = msg_bits_r + {60'd0, bits_add};
        end
      end
      ST_PAD: begin
        if (need80_r) begin
          put_en     = 1'b1;
          put_byte   = PAD_BYTE;
          need80_nxt = 1'b0;
        end else if (fill_r[1:0] != 2'd0) begin
          put_en = 1'b1;
        end else if (len_r) begin
          word_en   = 1'b1;
          word_val  = msg_bits_r[31:0];
          final_nxt = 1'b1;
        end else if (fill_r == 6'd56) begin
          word_en  = 1'b1;
          word_val = msg_bits_r[63:32];
          len_nxt  = 1'b1;
        end else begin
          word_en = 1'b1;
        end
      end
      ST_LOAD: begin
        if (cnt_r != 3'd0) begin
          v_nxt[cnt_m1] = hash_base;
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(HASH_WORDS)) begin
          state_nxt = ST_ROUND;
          round_nxt = '0;
        end
      end
      ST_ROUND: begin
        v_nxt[0]  = t_sum;
        v_nxt[1]  = v_r[0];
        v_nxt[2]  = {v_r[1][1:0], v_r[1][31:2]};
        v_nxt[3]  = v_r[2];
        v_nxt[4]  = v_r[3];
        round_nxt = round_r + 7'd1;
        if (round_r == 7'(ROUNDS - 1)) begin
          state_nxt = ST_UPD;
          cnt_nxt   = '0;
        end
      end
      ST_UPD: begin
        ram_we  = (cnt_r != 3'd0);
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(HASH_WORDS)) begin
          fresh_nxt = 1'b0;
          cnt_nxt   = '0;
          if (final_r) begin
            state_nxt = ST_OUT_RD;
          end else if (pad_r) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        out_word_nxt  = ram_rdata;
        out_idx_nxt   = cnt_r;
        out_lastw_nxt = (cnt_r == 3'(HASH_WORDS - 1));
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (cnt_r == 3'(HASH_WORDS - 1)) begin
            state_nxt    = ST_IDLE;
            cnt_nxt      = '0;
            fresh_nxt    = 1'b1;
            msg_bits_nxt = '0;
            pad_nxt      = 1'b0;
            need80_nxt   = 1'b0;
            len_nxt      = 1'b0;
            final_nxt    = 1'b0;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    w_shift  = 1'b0;
    w_word   = '0;
    if (put_en) begin
      acc_nxt  = {acc_r[15:0], put_byte};
      fill_nxt = fill_r + 6'd1;
      if (fill_r[1:0] == 2'd3) begin
        w_shift = 1'b1;
        w_word  = {acc_r, put_byte};
      end
    end
    if (word_en) begin
      fill_nxt = fill_r + 6'd4;
      w_shift  = 1'b1;
      w_word   = word_val;
    end
    if (state_r == ST_ROUND) begin
      w_shift = 1'b1;
      w_word  = {w_new[30:0], w_new[31]};
    end
    blk_full = (put_en && (fill_r == 6'd63)) || (word_en && (fill_r == 6'd60));
    if (blk_full) begin
      state_nxt = ST_LOAD;
      cnt_nxt   = '0;
    end else if ((state_r == ST_IDLE) && in_valid && in_last) begin
      state_nxt = ST_PAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      round_r     <= '0;
      fill_r      <= '0;
      msg_bits_r  <= '0;
      pad_r       <= 1'b0;
      need80_r    <= 1'b0;
      len_r       <= 1'b0;
      final_r     <= 1'b0;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      round_r     <= round_nxt;
      fill_r      <= fill_nxt;
      msg_bits_r  <= msg_bits_nxt;
      pad_r       <= pad_nxt;
      need80_r    <= need80_nxt;
      len_r       <= len_nxt;
      final_r     <= final_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    out_word_r  <= out_word_nxt;
    out_idx_r   <= out_idx_nxt;
    out_lastw_r <= out_lastw_nxt;
    for (int i = 0; i < HASH_WORDS; i++) begin
      v_r[i] <= v_nxt[i];
    end
    if (w_shift) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[BLOCK_WORDS - 1] <= w_word;
    end
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("Input accepted while a digest transaction is pending.");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (round_r < 7'(ROUNDS)))
    else $error("Round counter out of range.");

  a_digest_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=> !in_ready)
    else $error("Input reopened before the digest was complete.");

  a_len_align: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_PAD) && len_r) |-> ((fill_r == 6'd60) && !need80_r))
    else $error("Length word not placed at the end of the block.");

endmodule
`default_nettype wire

// ===== src/sha1_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module sha1_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 5
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire
